FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kft: assertion violated");

// Next-cycle implication, disabled during reset.
`define KFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kft: assertion violated");

`endif

FILE: hw/rtl/kft_pkg.sv
`default_nettype none

package kft_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 128;
    localparam int FLAG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [FLAG_W-1:0] HIDE_MASK_RESET = 32'h0000_0001;
    localparam logic [FLAG_W-1:0] LOCK_MASK_RESET = 32'h0000_0002;

    typedef enum logic [2:0] {
        REQ_LOOKUP = 3'd0,
        REQ_ADD    = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_UPDATE = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIDE_MASK = 2'd0,
        CFG_LOCK_MASK = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_SUM
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] flags_value;
        logic [31:0] test_mask;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [5:0]  found_index;
        logic [31:0] entry_flags;
        logic        flag_hit;
        logic [6:0]  entry_count;
        logic        any_hidden;
        logic        any_locked;
    } t_res;

    typedef struct packed {
        logic [FLAG_W-1:0] hide;
        logic [FLAG_W-1:0] lock;
    } t_masks;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              key_we;
        logic              flag_we;
        logic [IDX_W-1:0]  wr_addr;
        logic [KEY_W-1:0]  wr_key;
        logic [FLAG_W-1:0] wr_flags;
    } t_mem_cmd;

    function automatic t_res make_res(
        input logic              ok,
        input logic [IDX_W-1:0]  slot,
        input logic [FLAG_W-1:0] flags,
        input logic              hit,
        input logic [CNT_W-1:0]  count,
        input logic              hidden,
        input logic              locked
    );
        t_res res;
        res.ok          = ok;
        res.found_index = 6'(slot);
        res.entry_flags = flags;
        res.flag_hit    = hit;
        res.entry_count = 7'(count);
        res.any_hidden  = hidden;
        res.any_locked  = locked;
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kft_ram.sv
`default_nettype none

module kft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/kft_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module kft_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire kft_pkg::t_req             i_req,
    input  wire kft_pkg::t_masks           i_masks,
    output kft_pkg::t_mem_cmd              o_cmd,
    input  wire logic [kft_pkg::KEY_W-1:0]  i_key_rd,
    input  wire logic [kft_pkg::FLAG_W-1:0] i_flag_rd,
    output logic                           o_done,
    output kft_pkg::t_res                  o_res
);

    import kft_pkg::*;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_hidden, n_hidden;
    logic              r_locked, n_locked;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;
    logic              r_ok, n_ok;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic              r_acc_h, n_acc_h;
    logic              r_acc_l, n_acc_l;
    logic              r_done, n_done;
    t_res              r_res, n_res;

    logic              key_hit;
    logic              acc_h;
    logic              acc_l;
    logic [IDX_W-1:0]  last_idx;

    assign key_hit  = r_pend && (i_key_rd == {r_req.key_high, r_req.key_low});
    assign acc_h    = r_acc_h | (r_pend && ((i_flag_rd & i_masks.hide) != '0));
    assign acc_l    = r_acc_l | (r_pend && ((i_flag_rd & i_masks.lock) != '0));
    assign last_idx = IDX_W'(r_count - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_hidden <= 1'b0;
            r_locked <= 1'b0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_hidden <= n_hidden;
            r_locked <= n_locked;
            r_pend   <= n_pend;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_ok       <= n_ok;
        r_slot     <= n_slot;
        r_flags    <= n_flags;
        r_acc_h    <= n_acc_h;
        r_acc_l    <= n_acc_l;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_count    = r_count;
        n_hidden   = r_hidden;
        n_locked   = r_locked;
        n_rd_idx   = r_rd_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_ok       = r_ok;
        n_slot     = r_slot;
        n_flags    = r_flags;
        n_acc_h    = r_acc_h;
        n_acc_l    = r_acc_l;
        n_done     = 1'b0;
        n_res      = r_res;

        o_cmd          = '0;
        o_cmd.rd_addr  = r_rd_idx[IDX_W-1:0];
        o_cmd.wr_key   = {r_req.key_high, r_req.key_low};
        o_cmd.wr_flags = r_req.flags_value;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_ok     = 1'b0;
                    n_slot   = '0;
                    n_flags  = '0;
                    case (i_req.req_type)
                        REQ_LOOKUP, REQ_ADD, REQ_REMOVE, REQ_UPDATE: begin
                            n_state = S_SCAN;
                        end
                        REQ_CLEAR: begin
                            n_count  = '0;
                            n_hidden = 1'b0;
                            n_locked = 1'b0;
                            n_done   = 1'b1;
                            n_res    = make_res(1'b1, '0, '0, 1'b0, '0, 1'b0, 1'b0);
                        end
                        default: begin
                            n_done = 1'b1;
                            n_res  = make_res(1'b0, '0, '0, 1'b0, r_count,
                                              r_hidden, r_locked);
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (key_hit) begin
                    n_pend = 1'b0;
                    case (r_req.req_type)
                        REQ_LOOKUP: begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_res   = make_res(1'b1, r_pend_idx, i_flag_rd,
                                               (i_flag_rd & r_req.test_mask) != '0,
                                               r_count, r_hidden, r_locked);
                        end
                        REQ_ADD: begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_res   = make_res(1'b0, r_pend_idx, i_flag_rd, 1'b0,
                                               r_count, r_hidden, r_locked);
                        end
                        REQ_REMOVE: begin
                            n_ok    = 1'b1;
                            n_slot  = r_pend_idx;
                            n_flags = i_flag_rd;
                            n_count = r_count - 1'b1;
                            if (r_pend_idx != last_idx) begin
                                n_state = S_MOVE_RD;
                            end else begin
                                n_state  = S_SUM;
                                n_rd_idx = '0;
                                n_acc_h  = 1'b0;
                                n_acc_l  = 1'b0;
                            end
                        end
                        REQ_UPDATE: begin
                            o_cmd.flag_we = 1'b1;
                            o_cmd.wr_addr = r_pend_idx;
                            n_ok     = 1'b1;
                            n_slot   = r_pend_idx;
                            n_flags  = r_req.flags_value;
                            n_state  = S_SUM;
                            n_rd_idx = '0;
                            n_acc_h  = 1'b0;
                            n_acc_l  = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_res   = make_res(1'b0, '0, '0, 1'b0, r_count,
                                               r_hidden, r_locked);
                        end
                    endcase
                end else if (r_rd_idx < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx   = r_rd_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    case (r_req.req_type)
                        REQ_ADD: begin
                            if (r_count < CNT_W'(CAPACITY)) begin
                                o_cmd.key_we  = 1'b1;
                                o_cmd.flag_we = 1'b1;
                                o_cmd.wr_addr = r_count[IDX_W-1:0];
                                n_count  = r_count + 1'b1;
                                n_ok     = 1'b1;
                                n_slot   = r_count[IDX_W-1:0];
                                n_flags  = r_req.flags_value;
                                n_state  = S_SUM;
                                n_rd_idx = '0;
                                n_acc_h  = 1'b0;
                                n_acc_l  = 1'b0;
                            end else begin
                                n_state = S_IDLE;
                                n_done  = 1'b1;
                                n_res   = make_res(1'b0, '0, '0, 1'b0, r_count,
                                                   r_hidden, r_locked);
                            end
                        end
                        REQ_REMOVE, REQ_UPDATE: begin
                            n_state  = S_SUM;
                            n_rd_idx = '0;
                            n_acc_h  = 1'b0;
                            n_acc_l  = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_res   = make_res(1'b0, '0, '0, 1'b0, r_count,
                                               r_hidden, r_locked);
                        end
                    endcase
                end
            end

            S_MOVE_RD: begin
                // count already holds the index of the last entry
                o_cmd.rd_addr = r_count[IDX_W-1:0];
                n_state       = S_MOVE_WR;
            end

            S_MOVE_WR: begin
                o_cmd.key_we   = 1'b1;
                o_cmd.flag_we  = 1'b1;
                o_cmd.wr_addr  = r_slot;
                o_cmd.wr_key   = i_key_rd;
                o_cmd.wr_flags = i_flag_rd;
                n_state  = S_SUM;
                n_rd_idx = '0;
                n_pend   = 1'b0;
                n_acc_h  = 1'b0;
                n_acc_l  = 1'b0;
            end

            S_SUM: begin
                n_acc_h = acc_h;
                n_acc_l = acc_l;
                n_pend  = 1'b0;
                if (r_rd_idx < r_count) begin
                    n_pend   = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                end else begin
                    n_hidden = acc_h;
                    n_locked = acc_l;
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_res    = make_res(r_ok, r_slot, r_flags, 1'b0, r_count,
                                        acc_h, acc_l);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `KFT_ASSERT_NOW(a_done_in_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    `KFT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `KFT_ASSERT_NEXT(a_start_acts, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_done)
    `KFT_ASSERT_NOW(a_key_write_src, i_clk, i_rst_n, o_cmd.key_we,
                    r_state == S_MOVE_WR || r_req.req_type == REQ_ADD)

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_flag_table_top.sv
`default_nettype none

// Keyed flag table: up to CAPACITY entries of a 128-bit key and a 32-bit flag
// word, kept packed in slots 0..count-1 of two single-port-read RAMs. Pulse
// i_start while o_busy is low; one result appears on o_res for exactly one
// cycle with o_done high and cannot be held off, so capture it then. A lookup
// scans the keys linearly, one RAM read per cycle. Remove, update and an add
// of a new key scan, then sweep the flag RAM once more to rebuild the hidden
// and locked summaries; an add that finds its key or a full table skips it.
// Clear and unused codes finish without a scan. The mask registers may be
// written at any time through the config port but only affect summaries on
// the next rebuild; write them only while the block is idle.

module keyed_flag_table_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire kft_pkg::t_req                 i_req,
    output logic                               o_done,
    output kft_pkg::t_res                      o_res,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [kft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [kft_pkg::FLAG_W-1:0]    i_cfg_data
);

    import kft_pkg::*;

    t_masks            r_masks;
    t_mem_cmd          cmd;
    logic [KEY_W-1:0]  key_rd;
    logic [FLAG_W-1:0] flag_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks.hide <= HIDE_MASK_RESET;
            r_masks.lock <= LOCK_MASK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HIDE_MASK: r_masks.hide <= i_cfg_data;
                CFG_LOCK_MASK: r_masks.lock <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kft_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (cmd.key_we),
        .i_wr_addr (cmd.wr_addr),
        .i_wr_data (cmd.wr_key),
        .i_rd_addr (cmd.rd_addr),
        .o_rd_data (key_rd)
    );

    kft_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (CAPACITY)
    ) u_flag_ram (
        .i_clk     (i_clk),
        .i_we      (cmd.flag_we),
        .i_wr_addr (cmd.wr_addr),
        .i_wr_data (cmd.wr_flags),
        .i_rd_addr (cmd.rd_addr),
        .o_rd_data (flag_rd)
    );

    kft_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .o_busy    (o_busy),
        .i_req     (i_req),
        .i_masks   (r_masks),
        .o_cmd     (cmd),
        .i_key_rd  (key_rd),
        .i_flag_rd (flag_rd),
        .o_done    (o_done),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import kft_pkg::*;

    localparam logic [2:0]  REQ_SPARE_5 = 3'd5;
    localparam logic [2:0]  REQ_SPARE_6 = 3'd6;
    localparam logic [2:0]  REQ_SPARE_7 = 3'd7;
    localparam int          KEY_POOL    = 80;
    localparam int          SEGMENTS    = 6;
    localparam int          SEG_ITEMS   = 250;
    localparam int          DRAIN_LIMIT = 5000;
    localparam int          SETTLE      = 2 * CAPACITY + 10;
    localparam logic [63:0] ONES64      = '1;
    localparam logic [63:0] KC_H        = 64'h8000_0000_0000_0001;
    localparam logic [63:0] KC_L        = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] KD_L        = 64'hFEDC_BA98_7654_3210;
    localparam t_res        ZERO_RES    = '0;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_script_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    t_req                 i_req = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_HIDE_MASK;
    logic [FLAG_W-1:0]    i_cfg_data = '0;
    logic                 o_busy;
    logic                 o_done;
    t_res                 o_res;
    logic                 o_cfg_ready;

    // table model
    logic [KEY_W-1:0]  slot_key [CAPACITY];
    logic [FLAG_W-1:0] slot_flags [CAPACITY];
    int unsigned       live_count = 0;
    logic              hidden_now = 1'b0;
    logic              locked_now = 1'b0;
    logic [FLAG_W-1:0] hide_bits = HIDE_MASK_RESET;
    logic [FLAG_W-1:0] lock_bits = LOCK_MASK_RESET;

    t_res              pending_results [$];
    t_res              want;
    int                mismatch_count = 0;
    bit                growing = 1'b1;
    logic [KEY_W-1:0]  key_pool [KEY_POOL];
    t_script_row       script [22];

    keyed_flag_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("keyed_flag_table_top: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t: %s got %0h expected %0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    function automatic void refresh_summaries();
        hidden_now = 1'b0;
        locked_now = 1'b0;
        for (int s = 0; s < live_count; s++) begin
            if ((slot_flags[s] & hide_bits) != '0) hidden_now = 1'b1;
            if ((slot_flags[s] & lock_bits) != '0) locked_now = 1'b1;
        end
    endfunction

    function automatic t_res apply_request(input t_req r);
        t_res             res;
        int               slot;
        int               last;
        logic [KEY_W-1:0] key;
        res = '0;
        slot = -1;
        key = {r.key_high, r.key_low};
        for (int s = live_count - 1; s >= 0; s--)
            if (slot_key[s] == key) slot = s;
        case (r.req_type)
            REQ_LOOKUP: if (slot >= 0) begin
                res.ok = 1'b1;
                res.found_index = 6'(slot);
                res.entry_flags = slot_flags[slot];
                res.flag_hit = |(slot_flags[slot] & r.test_mask);
            end
            REQ_ADD: if (slot >= 0) begin
                res.found_index = 6'(slot);
                res.entry_flags = slot_flags[slot];
            end else if (live_count < CAPACITY) begin
                slot_key[live_count] = key;
                slot_flags[live_count] = r.flags_value;
                res.ok = 1'b1;
                res.found_index = 6'(live_count);
                res.entry_flags = r.flags_value;
                live_count++;
                refresh_summaries();
            end
            REQ_REMOVE: begin
                if (slot >= 0) begin
                    last = live_count - 1;
                    res.ok = 1'b1;
                    res.found_index = 6'(slot);
                    res.entry_flags = slot_flags[slot];
                    slot_key[slot] = slot_key[last];
                    slot_flags[slot] = slot_flags[last];
                    live_count = last;
                end
                refresh_summaries();
            end
            REQ_UPDATE: begin
                if (slot >= 0) begin
                    slot_flags[slot] = r.flags_value;
                    res.ok = 1'b1;
                    res.found_index = 6'(slot);
                    res.entry_flags = r.flags_value;
                end
                refresh_summaries();
            end
            REQ_CLEAR: begin
                live_count = 0;
                refresh_summaries();
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.entry_count = 7'(live_count);
        res.any_hidden = hidden_now;
        res.any_locked = locked_now;
        return res;
    endfunction

    // start stays high on return so back-to-back transactions need no re-raise
    task automatic issue(input t_req r, input bit typed, input t_res typed_res);
        t_res predicted;
        i_start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_busy);
        predicted = apply_request(r);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic program_masks(input logic [FLAG_W-1:0] hide,
                                 input logic [FLAG_W-1:0] lock);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_HIDE_MASK;
        i_cfg_data <= hide;
        do @(posedge i_clk); while (!o_cfg_ready);
        hide_bits = hide;
        i_cfg_index <= CFG_LOCK_MASK;
        i_cfg_data <= lock;
        do @(posedge i_clk); while (!o_cfg_ready);
        lock_bits = lock;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle_block();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int items);
        t_req             r;
        int               counted;
        int               pick;
        logic [KEY_W-1:0] key;
        counted = 0;
        while (counted < items) begin
            if ($urandom_range(49) == 0) growing = !growing;
            pick = $urandom_range(999);
            if ($urandom_range(9) == 0)
                key = {$urandom, $urandom, $urandom, $urandom};
            else if (live_count != 0 && $urandom_range(1) == 1)
                key = slot_key[$urandom_range(live_count - 1)];
            else
                key = key_pool[$urandom_range(KEY_POOL - 1)];
            {r.key_high, r.key_low} = key;
            if (pick < (growing ? 550 : 150)) r.req_type = REQ_ADD;
            else if (pick < (growing ? 700 : 400)) r.req_type = REQ_LOOKUP;
            else if (pick < (growing ? 780 : 750)) r.req_type = REQ_REMOVE;
            else if (pick < (growing ? 900 : 880)) r.req_type = REQ_UPDATE;
            else if (pick < (growing ? 903 : 885)) r.req_type = REQ_CLEAR;
            else if (pick < (growing ? 950 : 935)) r.req_type = 3'($urandom_range(5, 7));
            else r.req_type = REQ_LOOKUP;
            case ($urandom_range(3))
                0: r.flags_value = '0;
                1: r.flags_value = $urandom;
                2: r.flags_value = $urandom & $urandom & $urandom;
                default: r.flags_value = 32'h1 << $urandom_range(31);
            endcase
            case ($urandom_range(3))
                0: r.test_mask = '0;
                1: r.test_mask = '1;
                2: r.test_mask = $urandom;
                default: r.test_mask = $urandom & $urandom & $urandom;
            endcase
            issue(r, 1'b0, ZERO_RES);
            if (r.req_type <= REQ_CLEAR) counted++;
            if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                i_start <= 1'b0;
                repeat ($urandom_range(3) != 0 ? $urandom_range(1, 4)
                                               : $urandom_range(5, 140))
                    @(posedge i_clk);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_res), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_res.ok !== want.ok)
                    report_mismatch("ok", 64'(o_res.ok), 64'(want.ok));
                if (o_res.found_index !== want.found_index)
                    report_mismatch("found_index", 64'(o_res.found_index),
                                    64'(want.found_index));
                if (o_res.entry_flags !== want.entry_flags)
                    report_mismatch("entry_flags", 64'(o_res.entry_flags),
                                    64'(want.entry_flags));
                if (o_res.flag_hit !== want.flag_hit)
                    report_mismatch("flag_hit", 64'(o_res.flag_hit), 64'(want.flag_hit));
                if (o_res.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(o_res.entry_count),
                                    64'(want.entry_count));
                if (o_res.any_hidden !== want.any_hidden)
                    report_mismatch("any_hidden", 64'(o_res.any_hidden),
                                    64'(want.any_hidden));
                if (o_res.any_locked !== want.any_locked)
                    report_mismatch("any_locked", 64'(o_res.any_locked),
                                    64'(want.any_locked));
            end
        end
    end

    initial begin
        logic [FLAG_W-1:0] seg_hide;
        logic [FLAG_W-1:0] seg_lock;
        int                waited;

        // masks at reset values: hide bit 0, lock bit 1
        script = '{
            '{'{REQ_LOOKUP, ONES64, ONES64, 32'h0, 32'hFFFF_FFFF}, 1'b1, ZERO_RES},
            '{'{REQ_REMOVE, ONES64, ONES64, 32'h0, 32'h0}, 1'b1, ZERO_RES},
            '{'{REQ_UPDATE, ONES64, ONES64, 32'hFFFF_FFFF, 32'h0}, 1'b1, ZERO_RES},
            '{'{REQ_SPARE_5, ONES64, ONES64, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
              ZERO_RES},
            '{'{REQ_ADD, ONES64, ONES64, 32'hFFFF_FFFF, 32'h0}, 1'b1,
              '{1'b1, 6'd0, 32'hFFFF_FFFF, 1'b0, 7'd1, 1'b1, 1'b1}},
            '{'{REQ_ADD, ONES64, ONES64, 32'h0, 32'h0}, 1'b1,
              '{1'b0, 6'd0, 32'hFFFF_FFFF, 1'b0, 7'd1, 1'b1, 1'b1}},
            '{'{REQ_LOOKUP, ONES64, ONES64, 32'h0, 32'hFFFF_FFFF}, 1'b1,
              '{1'b1, 6'd0, 32'hFFFF_FFFF, 1'b1, 7'd1, 1'b1, 1'b1}},
            '{'{REQ_LOOKUP, ONES64, ONES64, 32'h0, 32'h0}, 1'b1,
              '{1'b1, 6'd0, 32'hFFFF_FFFF, 1'b0, 7'd1, 1'b1, 1'b1}},
            '{'{REQ_ADD, 64'h0, 64'h0, 32'h0, 32'h0}, 1'b1,
              '{1'b1, 6'd1, 32'h0, 1'b0, 7'd2, 1'b1, 1'b1}},
            '{'{REQ_ADD, KC_H, KC_L, 32'h0000_0002, 32'h0}, 1'b0, ZERO_RES},
            '{'{REQ_LOOKUP, KC_H, KD_L, 32'h0, 32'hFFFF_FFFF}, 1'b0, ZERO_RES},
            '{'{REQ_UPDATE, ONES64, ONES64, 32'h0, 32'h0}, 1'b0, ZERO_RES},
            '{'{REQ_SPARE_7, ONES64, ONES64, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0,
              ZERO_RES},
            '{'{REQ_SPARE_6, 64'h0, 64'h0, 32'h0, 32'h0}, 1'b0, ZERO_RES},
            '{'{REQ_LOOKUP, 64'h0, 64'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0, ZERO_RES},
            '{'{REQ_REMOVE, ONES64, ONES64, 32'h0, 32'h0}, 1'b0, ZERO_RES},
            '{'{REQ_LOOKUP, KC_H, KC_L, 32'h0, 32'h0000_0002}, 1'b0, ZERO_RES},
            '{'{REQ_REMOVE, 64'h0, 64'h0, 32'h0, 32'h0}, 1'b0, ZERO_RES},
            '{'{REQ_UPDATE, KC_H, KD_L, 32'h0000_0001, 32'h0}, 1'b0, ZERO_RES},
            '{'{REQ_ADD, KC_H, KD_L, 32'h0000_0001, 32'h0}, 1'b0, ZERO_RES},
            '{'{REQ_CLEAR, ONES64, ONES64, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
              '{1'b1, 6'd0, 32'h0, 1'b0, 7'd0, 1'b0, 1'b0}},
            '{'{REQ_LOOKUP, KC_H, KC_L, 32'h0, 32'hFFFF_FFFF}, 1'b1, ZERO_RES}
        };

        // neighbors share a key half so partial matches get exercised
        for (int k = 0; k < KEY_POOL; k++) begin
            key_pool[k] = {$urandom, $urandom, $urandom, $urandom};
            if (k % 4 == 1) key_pool[k][127:64] = key_pool[k-1][127:64];
            if (k % 4 == 2) key_pool[k][63:0] = key_pool[k-1][63:0];
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[n]) issue(script[n].req, script[n].typed, script[n].res);
        settle_block();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin seg_hide = '0; seg_lock = '1; end
                1: begin seg_hide = '1; seg_lock = '0; end
                2: begin seg_hide = $urandom & $urandom; seg_lock = $urandom & $urandom; end
                3: begin seg_hide = 32'h8000_0000; seg_lock = 32'h0000_0001; end
                4: begin seg_hide = HIDE_MASK_RESET; seg_lock = LOCK_MASK_RESET; end
                default: begin seg_hide = $urandom; seg_lock = $urandom; end
            endcase
            program_masks(seg_hide, seg_lock);
            run_random_phase(seg < 2 ? 17 : (seg < 4 ? 61 : 0), SEG_ITEMS);
            settle_block();
        end

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 64'(pending_results.size()), 64'd0);

        if (mismatch_count == 0) begin
            $display("keyed_flag_table_top: match");
        end else begin
            $display("keyed_flag_table_top: mismatch");
        end
        $finish;
    end

endmodule
